/* src/bmp_pixel_data_decoder_macros.svh */
// Assertion macros for the BMP pixel data decoder.
`ifndef BMP_PIXEL_DATA_DECODER_MACROS_SVH
`define BMP_PIXEL_DATA_DECODER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define BMPDEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmpdec: implication check failed");
// Next-cycle implication.
`define BMPDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmpdec: next-cycle check failed");
`else
`define BMPDEC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BMPDEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/bmpdec_pkg.sv */
// Types, codes and constants shared by the BMP pixel data decoder files.
package bmpdec_pkg;

   localparam int DEF_MAX_WIDTH     = 4096;
   localparam int DEF_MAX_HEIGHT    = 4096;
   localparam int DEF_PALETTE_DEPTH = 256;

   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int RB_W       = 14;
   localparam int DEPTH_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int IDX_W      = 8;
   localparam int RGB_W      = 24;
   localparam int PIX_W      = 32;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

   typedef enum logic [0:0] {
      OP_PALETTE = 1'b0,
      OP_PIXEL   = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_PIXEL_DEPTH  = 2'd2
   } csr_index_type;

   typedef enum logic [DEPTH_W-1:0] {
      DEPTH_1BPP  = 3'd0,
      DEPTH_4BPP  = 3'd1,
      DEPTH_8BPP  = 3'd2,
      DEPTH_24BPP = 3'd3,
      DEPTH_32BPP = 3'd4
   } depth_type;

   typedef struct packed {
      logic              op;
      logic [7:0]        data_byte;
      logic [IDX_W-1:0]  palette_index;
      logic [RGB_W-1:0]  palette_color;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_color;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               last_of_run;
      logic               last_of_image;
      logic               alpha_absent;
   } rsp_payload_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic [RGB_W-1:0]  color;
   } pal_wr_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
   } pal_rd_type;

endpackage

/* src/bmpdec_palette.sv */
// Palette memory with registered read and ABGR formatting of the entry.
module bmpdec_palette
   import bmpdec_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic             clock,
   input  pal_wr_type       wr,
   input  pal_rd_type       rd,
   output logic [PIX_W-1:0] color
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [RGB_W-1:0] mem [PALETTE_DEPTH];
   logic [RGB_W-1:0] rd_data_ff;
   logic             rd_oob_ff;

   // Drop writes beyond the palette; a read of such an index gives black.
   always_ff @(posedge clock) begin
      if (wr.en && (32'(wr.index) < 32'(PALETTE_DEPTH))) begin
         mem[wr.index[AW-1:0]] <= wr.color;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.index[AW-1:0]];
         rd_oob_ff  <= !(32'(rd.index) < 32'(PALETTE_DEPTH));
      end
   end

   // Swap file order 00RRGGBB into AABBGGRR.
   assign color = rd_oob_ff ? {ALPHA_OPAQUE, 24'h000000}
                            : {ALPHA_OPAQUE, rd_data_ff[7:0], rd_data_ff[15:8],
                               rd_data_ff[23:16]};

endmodule

/* src/bmp_pixel_data_decoder.sv */
// Top level of the BMP pixel data decoder: byte decode, pixel expansion, output stage.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  req_payload_type (palette write or byte)
//   rsp_      out        rsp_valid / rsp_stall  rsp_payload_type (one ABGR pixel)
//   csr_      in         csr_write              csr_index, csr_data (no read-back)
//
// One pixel leaves per cycle while rsp_stall is low; the expander works through one byte at a time:
// a 1bpp byte gives up to eight pixels, a 4bpp byte up to two, and an 8/24/32bpp byte at most one.
// An accepted byte is registered in the expander, and its first pixel then passes the output stage.
// Reset sets the CSRs to 1 x 1 at 8bpp and clears counters and valid flags; palette contents stay.
// rsp_stall holds the output stage and the palette read register; the expander keeps one
// byte in hand, and req_ takes a new beat while a pixel waits on rsp_ only if no byte is in hand.
module bmp_pixel_data_decoder
   import bmpdec_pkg::*;
#(
   parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

`include "bmp_pixel_data_decoder_macros.svh"

   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int XW    = RB_W + 3;   // byte index times eight
   localparam int DW    = XW + 1;     // signed room for width minus column
   localparam int SW    = 16;         // row stride in bytes

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [DEPTH_W-1:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         depth_ff  <= DEPTH_8BPP;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            CSR_PIXEL_DEPTH:  depth_ff  <= csr_data[DEPTH_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp dimensions into 1..MAX and fold undefined depth codes onto 8bpp.
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   depth_type        depth;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      case (depth_ff)
         DEPTH_1BPP:  depth = DEPTH_1BPP;
         DEPTH_4BPP:  depth = DEPTH_4BPP;
         DEPTH_24BPP: depth = DEPTH_24BPP;
         DEPTH_32BPP: depth = DEPTH_32BPP;
         default:     depth = DEPTH_8BPP;
      endcase
   end

   // ---------------------------------------------------------------- stream state
   logic [ROW_W-1:0]  row_ff;
   logic [RB_W-1:0]   rb_ff;
   logic [RB_W-2:0]   rb_div3_ff;    // rb_ff / 3, tracked alongside rb_ff
   logic [1:0]        rb_mod3_ff;
   logic [RGB_W-1:0]  asm_ff;
   logic [1:0]        phase_ff;
   logic              alpha_zero_ff;

   // ---------------------------------------------------------------- handshake
   logic req_fire, pix_fire, active, issue, job_done, out_free;
   logic job_valid_ff;
   logic out_valid_ff;

   assign req_fire = req_valid && !req_stall;
   assign pix_fire = req_fire && (req_payload.op == OP_PIXEL);
   assign active   = 32'(row_ff) < 32'(h_eff);

   // ---------------------------------------------------------------- byte decode
   logic [7:0]         b;
   logic               direct, complete;
   logic [XW-1:0]      x0;
   logic [3:0]         cap;
   logic [DW-1:0]      diff;
   logic               positive, hit, gen, last_row, img_end;
   logic               alpha_clear, alpha_next;
   logic [2:0]         n_minus1;
   logic [PIX_W-1:0]   direct_color;
   logic [COORD_W-1:0] y_cur;
   logic [SW-1:0]      w16, stride;
   logic               row_end;

   always_comb begin
      b        = req_payload.data_byte;
      direct   = (depth == DEPTH_24BPP) || (depth == DEPTH_32BPP);
      complete = (depth == DEPTH_24BPP) ? (phase_ff >= 2'd2) : (phase_ff == 2'd3);

      // First column this byte covers and how many pixels a byte can carry.
      case (depth)
         DEPTH_1BPP: begin
            x0  = {rb_ff, 3'b000};
            cap = 4'd8;
         end
         DEPTH_4BPP: begin
            x0  = XW'({rb_ff, 1'b0});
            cap = 4'd2;
         end
         DEPTH_24BPP: begin
            x0  = XW'(rb_div3_ff);
            cap = 4'd1;
         end
         DEPTH_32BPP: begin
            x0  = XW'(rb_ff[RB_W-1:2]);
            cap = 4'd1;
         end
         default: begin
            x0  = XW'(rb_ff);
            cap = 4'd1;
         end
      endcase

      // Pixels remaining in the row decide count and whether the row's last column is hit.
      diff     = DW'(w_eff) - {1'b0, x0};
      positive = !diff[DW-1] && (diff != '0);
      hit      = positive && (diff <= DW'(cap));
      gen      = positive && (!direct || complete);
      n_minus1 = hit ? 3'(diff - DW'(1)) : 3'(cap - 4'd1);
      last_row = 32'(row_ff) == (32'(h_eff) - 32'd1);
      img_end  = hit && last_row;

      alpha_clear = (depth == DEPTH_32BPP) && complete && positive && (b != 8'h00);
      alpha_next  = alpha_zero_ff && !alpha_clear;

      direct_color = (depth == DEPTH_24BPP) ? {ALPHA_OPAQUE, asm_ff[15:0], b}
                                            : {b, asm_ff};
      y_cur = COORD_W'(32'(h_eff) - 32'd1 - 32'(row_ff));

      // Row stride: bits per row rounded up to whole 32-bit words.
      w16 = SW'(w_eff);
      case (depth)
         DEPTH_1BPP:  stride = SW'(((w16 + SW'(31)) >> 5) << 2);
         DEPTH_4BPP:  stride = SW'(((w16 + SW'(7)) >> 3) << 2);
         DEPTH_24BPP: stride = SW'(((w16 + (w16 << 1) + SW'(3)) >> 2) << 2);
         DEPTH_32BPP: stride = SW'(w16 << 2);
         default:     stride = SW'(((w16 + SW'(3)) >> 2) << 2);
      endcase
      row_end = (SW'(rb_ff) + SW'(1)) >= stride;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         rb_ff         <= '0;
         rb_div3_ff    <= '0;
         rb_mod3_ff    <= '0;
         asm_ff        <= '0;
         phase_ff      <= '0;
         alpha_zero_ff <= 1'b1;
      end else if (pix_fire && active) begin
         alpha_zero_ff <= alpha_next;
         if (row_end) begin
            // Advance to the next stored row; drop any partial pixel.
            row_ff     <= row_ff + ROW_W'(1);
            rb_ff      <= '0;
            rb_div3_ff <= '0;
            rb_mod3_ff <= '0;
            asm_ff     <= '0;
            phase_ff   <= '0;
         end else begin
            rb_ff <= rb_ff + RB_W'(1);
            if (rb_ff == '1) begin
               rb_div3_ff <= '0;
               rb_mod3_ff <= '0;
            end else if (rb_mod3_ff == 2'd2) begin
               rb_div3_ff <= rb_div3_ff + (RB_W-1)'(1);
               rb_mod3_ff <= '0;
            end else begin
               rb_mod3_ff <= rb_mod3_ff + 2'd1;
            end
            if (direct) begin
               if (complete) begin
                  asm_ff   <= '0;
                  phase_ff <= '0;
               end else begin
                  asm_ff   <= {asm_ff[15:0], b};
                  phase_ff <= phase_ff + 2'd1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- expander
   depth_type          job_depth_ff;
   logic [7:0]         job_byte_ff;
   logic [2:0]         job_k_ff, job_last_ff;
   logic [COORD_W-1:0] job_x_ff, job_y_ff;
   logic               job_img_ff, job_alpha_ff, job_direct_ff;
   logic [PIX_W-1:0]   job_color_ff;
   logic               job_at_last;

   assign out_free    = !out_valid_ff || !rsp_stall;
   assign issue       = job_valid_ff && out_free;
   assign job_at_last = job_k_ff == job_last_ff;
   assign job_done    = issue && job_at_last;
   // Hold the input until the byte in hand issues its last pixel; this also keeps
   // palette writes behind every lookup of earlier bytes.
   assign req_stall   = job_valid_ff && !job_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (pix_fire && active && gen) begin
         job_valid_ff <= 1'b1;
      end else if (job_done) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire && active && gen) begin
         job_depth_ff  <= depth;
         job_byte_ff   <= b;
         job_k_ff      <= '0;
         job_last_ff   <= n_minus1;
         job_x_ff      <= x0[COORD_W-1:0];
         job_y_ff      <= y_cur;
         job_img_ff    <= img_end;
         job_alpha_ff  <= img_end && (depth == DEPTH_32BPP) && alpha_next;
         job_direct_ff <= direct;
         job_color_ff  <= direct_color;
      end else if (issue) begin
         job_k_ff <= job_k_ff + 3'd1;
         job_x_ff <= job_x_ff + COORD_W'(1);
      end
   end

   // Pick the palette index of the current pixel, leftmost bits first.
   pal_rd_type pal_rd;
   pal_wr_type pal_wr;
   logic [PIX_W-1:0] pal_color;

   always_comb begin
      pal_rd.en = issue && !job_direct_ff;
      case (job_depth_ff)
         DEPTH_1BPP: pal_rd.index = IDX_W'(job_byte_ff[3'd7 - job_k_ff]);
         DEPTH_4BPP: pal_rd.index = job_k_ff[0] ? IDX_W'(job_byte_ff[3:0])
                                                : IDX_W'(job_byte_ff[7:4]);
         default:    pal_rd.index = job_byte_ff;
      endcase
      pal_wr.en    = req_fire && (req_payload.op == OP_PALETTE);
      pal_wr.index = req_payload.palette_index;
      pal_wr.color = req_payload.palette_color;
   end

   bmpdec_palette #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock (clock),
      .wr    (pal_wr),
      .rd    (pal_rd),
      .color (pal_color)
   );

   // ---------------------------------------------------------------- output stage
   logic               out_direct_ff;
   logic [PIX_W-1:0]   out_color_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic               out_run_ff, out_img_ff, out_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         out_direct_ff <= job_direct_ff;
         out_color_ff  <= job_color_ff;
         out_x_ff      <= job_x_ff;
         out_y_ff      <= job_y_ff;
         out_run_ff    <= job_at_last;
         out_img_ff    <= job_at_last && job_img_ff;
         out_alpha_ff  <= job_at_last && job_alpha_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      rsp_payload.pixel_color   = out_direct_ff ? out_color_ff : pal_color;
      rsp_payload.pixel_x       = out_x_ff;
      rsp_payload.pixel_y       = out_y_ff;
      rsp_payload.last_of_run   = out_run_ff;
      rsp_payload.last_of_image = out_img_ff;
      rsp_payload.alpha_absent  = out_alpha_ff;
   end

   // ---------------------------------------------------------------- checks
   `BMPDEC_ASSERT_IMPLY(a_img_ends_run, clock, reset, rsp_valid && rsp_payload.last_of_image, rsp_payload.last_of_run)
   `BMPDEC_ASSERT_IMPLY(a_alpha_with_img, clock, reset, rsp_valid && rsp_payload.alpha_absent, rsp_payload.last_of_image)
   `BMPDEC_ASSERT_IMPLY(a_pal_write_safe, clock, reset, pal_wr.en && job_valid_ff, issue && job_at_last)
   `BMPDEC_ASSERT_NEXT(a_issue_lands, clock, reset, issue, out_valid_ff)

endmodule
